// File: rtl/cost_pkg.sv
// Package for the card object-start table: shared constants, operation codes
// and the lane control struct. Depends on nothing.
`timescale 1ns / 1ps

package cost_pkg;

    localparam int NUM_CARDS_DEF  = 4096;
    localparam int CARD_BITS      = 8;
    localparam int ALIGN_BITS     = 4;
    localparam int LANES          = 4;
    localparam int LANE_BITS      = 2;
    localparam int MARK_W         = 16;
    localparam int OFFSET_W       = 8;

    localparam logic [OFFSET_W-1:0] INSIDE_OBJECT = 8'hff;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_FIND   = 2'd1,
        OP_SWEEP  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        UPD_RECORD = 2'd0,
        UPD_SWEEP  = 2'd1,
        UPD_CLEAR  = 2'd2
    } upd_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        upd_t mode;
    } lane_ctrl_t;

endpackage

// File: rtl/cost_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module cost_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/cost_lane.sv
// One table lane: a bank of start offsets for the cards of one lane position
// and the update logic for record, sweep and clear. Depends on cost_pkg, cost_ram.
`timescale 1ns / 1ps

module cost_lane
    import cost_pkg::*;
#(
    parameter int ROWS = NUM_CARDS_DEF / LANES,
    localparam int AW  = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                 clk,
    input  lane_ctrl_t           ctrl,
    input  logic [AW-1:0]        row,
    input  logic [MARK_W-1:0]    card_marks,
    input  logic [OFFSET_W-1:0]  rec_low,
    output logic [OFFSET_W-1:0]  rd_data
);

    logic [OFFSET_W-1:0]  wr_data;
    logic [MARK_W-1:0]    shifted;

    // Position of the lowest set bit; only used when some bit is set.
    function automatic logic [ALIGN_BITS-1:0] lowest_set(input logic [MARK_W-1:0] v);
        logic [ALIGN_BITS-1:0] n;
        n = '0;
        for (int i = MARK_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = ALIGN_BITS'(i);
            end
        end
        return n;
    endfunction

    assign shifted = card_marks >> rd_data[OFFSET_W-1:ALIGN_BITS];

    always_comb
    begin
        unique case (ctrl.mode)
            UPD_RECORD:
            begin
                wr_data = (rec_low < rd_data) ? rec_low : rd_data;
            end
            UPD_SWEEP:
            begin
                if (rd_data == INSIDE_OBJECT || shifted == '0)
                begin
                    wr_data = INSIDE_OBJECT;
                end
                else
                begin
                    wr_data = rd_data + {lowest_set(shifted), {ALIGN_BITS{1'b0}}};
                end
            end
            UPD_CLEAR:
            begin
                wr_data = INSIDE_OBJECT;
            end
            default:
            begin
                wr_data = INSIDE_OBJECT;
            end
        endcase
    end

    cost_ram #(
        .WIDTH (OFFSET_W),
        .DEPTH (ROWS)
    ) u_bank (
        .clk     (clk),
        .we      (ctrl.wr_en),
        .wr_addr (row),
        .wr_data (wr_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (row),
        .rd_data (rd_data)
    );

endmodule

// File: rtl/cost_merge.sv
// Merge stage for the backward walk: picks the highest lane at or below the
// limit whose entry holds an object start. Depends on cost_pkg.
`timescale 1ns / 1ps

module cost_merge
    import cost_pkg::*;
(
    input  logic [LANES-1:0][OFFSET_W-1:0] lane_data,
    input  logic [LANE_BITS-1:0]           limit,
    output logic                           hit,
    output logic [LANE_BITS-1:0]           hit_lane,
    output logic [OFFSET_W-1:0]            hit_off
);

    always_comb
    begin
        hit      = 1'b0;
        hit_lane = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (LANE_BITS'(k) <= limit && lane_data[k] != INSIDE_OBJECT)
            begin
                hit      = 1'b1;
                hit_lane = LANE_BITS'(k);
            end
        end
        hit_off = lane_data[hit_lane];
    end

endmodule

// File: rtl/card_object_start_table.sv
// Card object-start table top level, built from cost_pkg, cost_lane and cost_merge.
// Record and sweep read the row of the request and then write it back updated; find
// reads one row of four cards at a time, walking back until a start is found or row 0
// is passed; clear sets every row to 255 in turn. Out-of-heap records and finds of card 0
// go straight to the result. One request at a time: the next is taken once the result is loaded.
// Reset starts a clearing pass over ROWS = ceil(NUM_CARDS/4) rows setting entries to 255.
`timescale 1ns / 1ps

module card_object_start_table
    import cost_pkg::*;
#(
    parameter int NUM_CARDS = NUM_CARDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [63:0] object_address,
    input  logic [11:0] card_number,
    input  logic [9:0]  mark_word_index,
    input  logic [63:0] mark_word,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] found_address,
    output logic        error,
    // Configuration write channel for heap_start.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);

    // The table is split into four lanes by the two low bits of the card
    // number, so one row holds the four cards of one mark word.
    localparam int ROWS = (NUM_CARDS + LANES - 1) / LANES;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [63:0] HEAP_SPAN    = 64'(NUM_CARDS) << CARD_BITS;
    localparam logic [31:0] NUM_CARDS_W  = 32'(NUM_CARDS);
    localparam logic [31:0] ROWS_W       = 32'(ROWS);
    localparam logic [AW-1:0] LAST_ROW   = AW'(ROWS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_UPD   = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [63:0]          heap_start_reg, heap_start_next;
    op_t                  op_reg, op_next;
    logic [AW-1:0]        row_reg, row_next;
    logic [LANE_BITS-1:0] limit_reg, limit_next;
    logic [LANE_BITS-1:0] rec_lane_reg, rec_lane_next;
    logic [OFFSET_W-1:0]  rec_low_reg, rec_low_next;
    logic [63:0]          mark_reg, mark_next;
    logic [LANES-1:0]     sweep_en_reg, sweep_en_next;
    logic [AW-1:0]        clr_row_reg, clr_row_next;
    logic                 clr_resp_reg, clr_resp_next;
    logic [63:0]          res_found_reg, res_found_next;
    logic                 res_err_reg, res_err_next;
    logic                 out_valid_reg, out_valid_next;
    logic [63:0]          found_address_reg, found_address_next;
    logic                 error_reg, error_next;

    logic [63:0]                    rel;
    logic [11:0]                    find_start;
    logic [LANES-1:0]               sweep_en;
    logic                           in_accept;
    logic                           out_load;
    logic                           lane_rd;
    logic [LANES-1:0]               lane_wr;
    upd_t                           lane_mode;
    logic [AW-1:0]                  lane_row;
    logic [LANES-1:0][OFFSET_W-1:0] lane_data;
    logic                           hit;
    logic [LANE_BITS-1:0]           hit_lane;
    logic [OFFSET_W-1:0]            hit_off;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Offset of the recorded object from the heap base, wrapping.
    assign rel = object_address - heap_start_reg;

    // The walk starts at the card just before the one asked for.
    assign find_start = card_number - 12'd1;

    // A sweep updates only the cards of its mark word that exist.
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            sweep_en[k] = {20'd0, mark_word_index, LANE_BITS'(k)} < NUM_CARDS_W;
        end
    end

    // The result register is loaded when it is empty or being drained.
    assign out_load = (state_reg == S_RESP) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next         = state_reg;
        heap_start_next    = heap_start_reg;
        op_next            = op_reg;
        row_next           = row_reg;
        limit_next         = limit_reg;
        rec_lane_next      = rec_lane_reg;
        rec_low_next       = rec_low_reg;
        mark_next          = mark_reg;
        sweep_en_next      = sweep_en_reg;
        clr_row_next       = clr_row_reg;
        clr_resp_next      = clr_resp_reg;
        res_found_next     = res_found_reg;
        res_err_next       = res_err_reg;
        found_address_next = found_address_reg;
        error_next         = error_reg;
        out_valid_next     = out_valid_reg;
        lane_rd            = 1'b0;
        lane_wr            = '0;
        lane_mode          = UPD_CLEAR;

        if (cfg_valid)
        begin
            heap_start_next = cfg_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // One row of all four lanes is set to 255 each cycle.
                lane_wr   = '1;
                lane_mode = UPD_CLEAR;
                if (clr_row_reg == LAST_ROW)
                begin
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? S_RESP : S_IDLE;
                end
                else
                begin
                    clr_row_next = clr_row_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next        = op_t'(op);
                    res_found_next = '0;
                    res_err_next   = 1'b0;
                    unique case (op_t'(op))
                        OP_RECORD:
                        begin
                            rec_low_next  = object_address[OFFSET_W-1:0];
                            rec_lane_next = rel[CARD_BITS+LANE_BITS-1:CARD_BITS];
                            row_next      = AW'(rel >> (CARD_BITS + LANE_BITS));
                            if (rel >= HEAP_SPAN)
                            begin
                                res_err_next = 1'b1;
                                state_next   = S_RESP;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_FIND:
                        begin
                            row_next   = AW'(find_start >> LANE_BITS);
                            limit_next = find_start[LANE_BITS-1:0];
                            if ({20'd0, card_number} >= NUM_CARDS_W)
                            begin
                                res_err_next = 1'b1;
                                state_next   = S_RESP;
                            end
                            else if (card_number == 12'd0)
                            begin
                                res_found_next = heap_start_reg;
                                state_next     = S_RESP;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_SWEEP:
                        begin
                            mark_next     = mark_word;
                            sweep_en_next = sweep_en;
                            row_next      = AW'(mark_word_index);
                            res_err_next  = !(&sweep_en);
                            if ({22'd0, mark_word_index} < ROWS_W)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            clr_row_next  = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                lane_rd    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                unique case (op_reg)
                    OP_RECORD:
                    begin
                        lane_mode              = UPD_RECORD;
                        lane_wr[rec_lane_reg]  = 1'b1;
                        state_next             = S_RESP;
                    end
                    OP_SWEEP:
                    begin
                        lane_mode  = UPD_SWEEP;
                        lane_wr    = sweep_en_reg;
                        state_next = S_RESP;
                    end
                    OP_FIND:
                    begin
                        // The card number of the hit is the row and lane
                        // concatenated, so the object address is one add.
                        if (hit)
                        begin
                            res_found_next = heap_start_reg
                                           + 64'({row_reg, hit_lane, hit_off});
                            state_next     = S_RESP;
                        end
                        else if (row_reg == '0)
                        begin
                            res_err_next = 1'b1;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            row_next   = row_reg - AW'(1);
                            limit_next = '1;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    found_address_next = res_found_reg;
                    error_next         = res_err_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            heap_start_reg <= '0;
            clr_row_reg    <= '0;
            clr_resp_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            heap_start_reg <= heap_start_next;
            clr_row_reg    <= clr_row_next;
            clr_resp_reg   <= clr_resp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        row_reg           <= row_next;
        limit_reg         <= limit_next;
        rec_lane_reg      <= rec_lane_next;
        rec_low_reg       <= rec_low_next;
        mark_reg          <= mark_next;
        sweep_en_reg      <= sweep_en_next;
        res_found_reg     <= res_found_next;
        res_err_reg       <= res_err_next;
        found_address_reg <= found_address_next;
        error_reg         <= error_next;
    end

    // The clearing pass addresses its own row counter; every other access
    // goes to the row of the current request.
    assign lane_row = (state_reg == S_CLEAR) ? clr_row_reg : row_reg;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        lane_ctrl_t ctrl;

        assign ctrl.rd_en = lane_rd;
        assign ctrl.wr_en = lane_wr[k];
        assign ctrl.mode  = lane_mode;

        cost_lane #(
            .ROWS (ROWS)
        ) u_lane (
            .clk        (clk),
            .ctrl       (ctrl),
            .row        (lane_row),
            .card_marks (mark_reg[k*MARK_W +: MARK_W]),
            .rec_low    (rec_low_reg),
            .rd_data    (lane_data[k])
        );
    end

    cost_merge u_merge (
        .lane_data (lane_data),
        .limit     (limit_reg),
        .hit       (hit),
        .hit_lane  (hit_lane),
        .hit_off   (hit_off)
    );

    assign out_valid     = out_valid_reg;
    assign found_address = found_address_reg;
    assign error         = error_reg;

`ifndef SYNTHESIS
    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> found_address == 64'd0)
        else $error("error result carries a nonzero address");

    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result appeared without a response state");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> lane_wr == '0)
        else $error("table written while idle");

    a_clr_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        clr_row_reg <= LAST_ROW)
        else $error("clearing pass row out of range");

    a_clear_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && op == OP_CLEAR |=> state_reg == S_CLEAR)
        else $error("clear request did not start a clearing pass");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for card_object_start_table: record, find, sweep and clear
// requests checked against an in-bench model of the per-card start offsets.
// Depends on cost_pkg and card_object_start_table.
`timescale 1ns / 1ps

module tb_top;
    import cost_pkg::*;

    localparam int TABLE_CARDS = NUM_CARDS_DEF;
    localparam logic [63:0] HEAP_BYTES = 64'(TABLE_CARDS) << CARD_BITS;

    // One request as the sender presents it.
    typedef struct {
        op_t         code;
        logic [63:0] addr;
        logic [11:0] card;
        logic [9:0]  word_idx;
        logic [63:0] marks;
    } request_t;

    // One expected result, tagged with the operation for messages.
    typedef struct {
        op_t         code;
        logic [63:0] addr;
        logic        err;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = OP_RECORD;
    logic [63:0] object_address = '0;
    logic [11:0] card_number = '0;
    logic [9:0]  mark_word_index = '0;
    logic [63:0] mark_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] found_address;
    logic        error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_data = '0;

    // Model state: the heap base and one start offset per card.
    logic [63:0] heap_base;
    logic [7:0]  card_offsets [TABLE_CARDS];

    result_t     pending_results [$];
    result_t     oldest_result;
    int          mismatches = 0;
    bit          sender_gaps = 1'b1;

    // Receiver control: a long hold is asked for by a test and counted below.
    bit          long_hold_request = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          free_left = 0;

    card_object_start_table #(
        .NUM_CARDS(TABLE_CARDS)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .object_address  (object_address),
        .card_number     (card_number),
        .mark_word_index (mark_word_index),
        .mark_word       (mark_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found_address   (found_address),
        .error           (error),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    // Gap length used for both the sender and the receiver: mostly none or
    // short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic request_t make_request(op_t code, logic [63:0] addr, logic [11:0] card,
                                              logic [9:0] word_idx, logic [63:0] marks);
        request_t rq;
        rq.code     = code;
        rq.addr     = addr;
        rq.card     = card;
        rq.word_idx = word_idx;
        rq.marks    = marks;
        return rq;
    endfunction

    // Applies one request to the model table and returns what the block must
    // answer. Records, sweeps and clears change the table; find only reads it.
    function automatic result_t table_response(request_t rq);
        result_t     res;
        logic [63:0] rel;
        logic [15:0] bits;
        int          c;
        int          n;
        res.code = rq.code;
        res.addr = '0;
        res.err  = 1'b0;
        case (rq.code)
            OP_RECORD:
            begin
                // The card comes from the heap-relative address, but the
                // offset is the low byte of the address itself.
                rel = rq.addr - heap_base;
                if (rel >= HEAP_BYTES)
                    res.err = 1'b1;
                else
                begin
                    c = int'(rel >> CARD_BITS);
                    if (rq.addr[7:0] < card_offsets[c])
                        card_offsets[c] = rq.addr[7:0];
                end
            end
            OP_FIND:
            begin
                if (int'(rq.card) >= TABLE_CARDS)
                    res.err = 1'b1;
                else if (rq.card == 0)
                    res.addr = heap_base;
                else
                begin
                    // Walk back from the card before the one asked for.
                    c = int'(rq.card) - 1;
                    while (card_offsets[c] == INSIDE_OBJECT && c > 0)
                        c--;
                    if (card_offsets[c] == INSIDE_OBJECT)
                        res.err = 1'b1;
                    else
                        res.addr = heap_base + (64'(c) << CARD_BITS) + 64'(card_offsets[c]);
                end
            end
            OP_SWEEP:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    c = int'(rq.word_idx) * LANES + k;
                    if (c >= TABLE_CARDS)
                        res.err = 1'b1;
                    else if (card_offsets[c] != INSIDE_OBJECT)
                    begin
                        bits = rq.marks[MARK_W*k +: MARK_W] >>
                               (card_offsets[c] >> ALIGN_BITS);
                        if (bits == 0)
                            card_offsets[c] = INSIDE_OBJECT;
                        else
                        begin
                            n = 0;
                            while (!bits[n])
                                n++;
                            card_offsets[c] = card_offsets[c] + 8'(n << ALIGN_BITS);
                        end
                    end
                end
            end
            default:
            begin
                foreach (card_offsets[i])
                    card_offsets[i] = INSIDE_OBJECT;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Presents one request, holds it until it is taken, then records what the
    // block should answer. A random gap may follow before the next request.
    task automatic send_request(request_t rq);
        int gap;
        in_valid        <= 1'b1;
        op              <= rq.code;
        object_address  <= rq.addr;
        card_number     <= rq.card;
        mark_word_index <= rq.word_idx;
        mark_word       <= rq.marks;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_results.push_back(table_response(rq));
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic record_at(logic [63:0] addr);
        send_request(make_request(OP_RECORD, addr, 12'(rand64()), 10'(rand64()), rand64()));
    endtask

    task automatic find_card(logic [11:0] card);
        send_request(make_request(OP_FIND, rand64(), card, 10'(rand64()), rand64()));
    endtask

    task automatic sweep_word(logic [9:0] word_idx, logic [63:0] marks);
        send_request(make_request(OP_SWEEP, rand64(), 12'(rand64()), word_idx, marks));
    endtask

    task automatic clear_table();
        send_request(make_request(OP_CLEAR, rand64(), 12'(rand64()), 10'(rand64()), rand64()));
    endtask

    // Stops offering requests and waits until every answer has come back.
    // Each request yields exactly one result, so an empty queue means idle.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the heap base; only called when no result is pending.
    task automatic write_heap_base(logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        heap_base = value;
    endtask

    // Directed checks with the heap at address zero: card zero, failed walks,
    // heap edges, the minimum rule of record, sweep shifts and clear.
    task automatic test_directed_edges();
        write_heap_base(64'h0);
        find_card(12'd0);
        find_card(12'd1);
        record_at(64'h0);
        record_at(HEAP_BYTES - 1);
        record_at(HEAP_BYTES);
        record_at(64'hFFFF_FFFF_FFFF_FFFF);
        record_at(64'h180);
        record_at(64'h150);
        record_at(64'h1A0);
        find_card(12'd2);
        find_card(12'd4095);
        // Card 0 has no mark and loses its start; card 1 moves forward to the granule
        // at 0x80; the other two cards hold no start and stay as they are.
        sweep_word(10'd0, {16'hFFFF, 16'hFFFF, 16'h0100, 16'h0000});
        find_card(12'd1);
        find_card(12'd2);
        record_at(64'h3F0);
        // Card 3 keeps its start on the top granule; card 1 has no mark left.
        sweep_word(10'd0, {16'h8000, 16'h0000, 16'h001F, 16'h0000});
        record_at(HEAP_BYTES - 256 + 64'h20);
        sweep_word(10'd1023, 64'hFFFF_FFFF_FFFF_FFFF);
        find_card(12'd4095);
        clear_table();
        find_card(12'd4);
        wait_all_results();
    endtask

    // Heap base at the top of the address space, so addresses wrap.
    task automatic test_heap_wrap();
        write_heap_base(64'hFFFF_FFFF_FFFF_FFFF);
        record_at(64'h0F);
        record_at(64'hFFFF_FFFF_FFFF_FFFE);
        record_at(HEAP_BYTES - 1);
        record_at(HEAP_BYTES - 2);
        find_card(12'd0);
        find_card(12'd1);
        find_card(12'd4095);
        sweep_word(10'd0, 64'h0000_0000_0000_0001);
        find_card(12'd2);
        clear_table();
        wait_all_results();
    endtask

    // Mostly well-formed traffic clustered in a moving window of cards, so
    // records, sweeps and finds act on the same entries. The rest is noise:
    // addresses outside the heap, far cards and far mark words.
    task automatic test_random_traffic(int count);
        int          window;
        int          r;
        int          card;
        logic [63:0] marks;
        window = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                window = $urandom_range(0, TABLE_CARDS - 80) & ~(LANES - 1);
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                card = window + $urandom_range(0, 63);
                if ($urandom_range(0, 99) < 85)
                    record_at(heap_base + (64'(card) << CARD_BITS) + 64'($urandom_range(0, 255)));
                else if ($urandom_range(0, 1) == 0)
                    record_at(rand64());
                else if ($urandom_range(0, 1) == 0)
                    record_at(heap_base + HEAP_BYTES + 64'($urandom_range(0, 3)));
                else
                    record_at(heap_base - 64'($urandom_range(1, 4)));
            end
            else if (r < 75)
            begin
                if ($urandom_range(0, 99) < 85)
                    find_card(12'(window + $urandom_range(0, 79)));
                else
                    find_card(12'(rand64()));
            end
            else if (r < 97)
            begin
                case ($urandom_range(0, 3))
                    0: marks = rand64();
                    1: marks = rand64() & rand64() & rand64();
                    2: marks = rand64() & {{16{1'($urandom)}}, {16{1'($urandom)}},
                                           {16{1'($urandom)}}, {16{1'($urandom)}}};
                    default: marks = 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
                if ($urandom_range(0, 99) < 80)
                    sweep_word(10'((window / LANES) + $urandom_range(0, 15)), marks);
                else
                    sweep_word(10'(rand64()), marks);
            end
            else
                clear_table();
        end
        wait_all_results();
    endtask

    // The receiver holds off for a long stretch while requests keep coming
    // back to back, so the block fills and stalls its request side.
    task automatic test_backpressure();
        int card;
        sender_gaps = 1'b0;
        long_hold_request = 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            card = $urandom_range(8, 200);
            case (i % 3)
                0: record_at(heap_base + (64'(card) << CARD_BITS) + 64'($urandom_range(0, 255)));
                1: find_card(12'(card));
                default: sweep_word(10'(card / LANES), rand64());
            endcase
        end
        sender_gaps = 1'b1;
        wait_all_results();
    endtask

    // Receiver: random stalls of mixed length, runs without stalls, and a
    // long hold counted here when a test asks for one.
    always @(posedge clk)
    begin
        if (long_hold_request)
        begin
            long_hold_request = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            free_left--;
            out_stall <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            free_left = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 10);
            out_stall <= 1'b0;
        end
    end

    // Every result taken is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result: address %h error %b",
                                          found_address, error));
            else
            begin
                oldest_result = pending_results.pop_front();
                if (found_address !== oldest_result.addr)
                    report_mismatch($sformatf("%s: found_address %h, expected %h",
                                              oldest_result.code.name(), found_address,
                                              oldest_result.addr));
                if (error !== oldest_result.err)
                    report_mismatch($sformatf("%s: error %b, expected %b",
                                              oldest_result.code.name(), error,
                                              oldest_result.err));
            end
        end
    end

    initial
    begin
        heap_base = '0;
        foreach (card_offsets[i])
            card_offsets[i] = INSIDE_OBJECT;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_heap_wrap();
        write_heap_base(rand64());
        test_random_traffic(150);
        write_heap_base(64'hFFFF_FFFF_FFF0_0000);
        test_random_traffic(150);
        write_heap_base(rand64());
        test_random_traffic(150);
        test_backpressure();

        wait_all_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Worst case is every request a full walk back over the table, plus long
    // gaps and stalls, for some 550 requests, plus the clearing pass after
    // reset. Allow several times that worst case.
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: card_object_start_table.f
rtl/cost_pkg.sv
rtl/cost_ram.sv
rtl/cost_lane.sv
rtl/cost_merge.sv
rtl/card_object_start_table.sv
tb/tb_top.sv
